FILE: rtl/core/aiuer_pkg.sv
package aiuer_pkg;

    // Frame buffer geometry
    localparam int FRAME_BYTES = 2048;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int HDR_BYTES   = 42;

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 64;
    localparam logic [1:0] REG_DEVICE_MAC = 2'd0;
    localparam logic [1:0] REG_DEVICE_IP  = 2'd1;
    localparam logic [1:0] REG_ECHO_PORT  = 2'd2;

    localparam logic [31:0] DEVICE_IP_RST = 32'd167772687;
    localparam logic [15:0] ECHO_PORT_RST = 16'd8080;

    // Verdict codes
    localparam logic [3:0] V_NONE    = 4'd0;
    localparam logic [3:0] V_ARP     = 4'd1;
    localparam logic [3:0] V_ICMP    = 4'd2;
    localparam logic [3:0] V_UDP     = 4'd3;
    localparam logic [3:0] V_SHORT   = 4'd4;
    localparam logic [3:0] V_MALFORM = 4'd5;
    localparam logic [3:0] V_NOTOURS = 4'd6;
    localparam logic [3:0] V_UNSUP   = 4'd7;
    localparam logic [3:0] V_BUSY    = 4'd8;
    localparam logic [3:0] V_LONG    = 4'd9;

    // Reply kinds
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_ARP  = 2'd1;
    localparam logic [1:0] K_ICMP = 2'd2;
    localparam logic [1:0] K_UDP  = 2'd3;

    // Protocol constants
    localparam logic [15:0] ETH_ARP      = 16'h0806;
    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [15:0] ARP_HTYPE    = 16'h0001;
    localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
    localparam logic [7:0]  ARP_HLEN     = 8'd6;
    localparam logic [7:0]  ARP_PLEN     = 8'd4;
    localparam logic [7:0]  PROTO_ICMP   = 8'h01;
    localparam logic [7:0]  PROTO_UDP    = 8'h11;
    localparam logic [7:0]  ICMP_ECHO_RQ = 8'd8;
    localparam logic [3:0]  IPV4_VER    = 4'd4;
    localparam logic [3:0]  IP_IHL      = 4'd5;
    localparam int ETH_HDR_LEN = 14;
    localparam int IP_END      = 34;
    localparam int L4_MIN_LEN  = 42;
    localparam int ICMP_MIN    = 28;
    localparam int UDP_MIN     = 8;
    localparam int ICMP_SUM_START = 38;

    // Fixed middle of an ARP reply: ethertype, htype, ptype, hlen, plen, opcode
    localparam logic [7:0] ARP_FIXED [10] = '{8'h08, 8'h06, 8'h00, 8'h01, 8'h08,
                                              8'h00, 8'h06, 8'h04, 8'h00, 8'h02};

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  reply_byte;
        logic        reply_valid;
        logic        reply_end;
        logic [3:0]  verdict;
        logic [11:0] reply_length;
    } t_out_item;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic [3:0]       verdict;
        logic [1:0]       kind;
        logic [CNT_W-1:0] total;
    } t_class;

    // Fold a one's-complement sum to 16 bits and invert
    function automatic logic [15:0] fold_not(input logic [27:0] s);
        logic [16:0] t1;
        logic [16:0] t2;
        t1 = {1'b0, s[15:0]} + {5'b0, s[27:16]};
        t2 = {1'b0, t1[15:0]} + {16'b0, t1[16]};
        return ~t2[15:0];
    endfunction

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        return mac[8*(5 - int'(k)) +: 8];
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        return ip[8*(3 - int'(k)) +: 8];
    endfunction

endpackage

FILE: rtl/core/arp_icmp_udp_echo_responder.sv
// Channel   | Direction | Handshake                 | Word
// ----------+-----------+---------------------------+--------------------------------
// input     | in        | i_in_valid / o_in_stall   | i_item  (op, data_byte, last)
// result    | out       | o_out_valid / i_out_stall | o_result (byte, flags, verdict)
// config    | in        | APB psel/penable/pwrite   | 64-bit registers at 0, 8, 16
//
// One word in, one word out. A word may be accepted every cycle while o_in_stall is low;
// each result passes the frame-buffer read and middle stage, then the output register.
// The single-port frame buffer is the only memory: a receive word writes it,
// a fetch word reads it; header bytes 0..41 are also held in flops for classification.
// Synchronous active-low reset clears all control state; the frame buffer is not cleared.
// A stalled output holds; the middle stage still takes one word while the output waits.
module arp_icmp_udp_echo_responder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  aiuer_pkg::t_in_item           i_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output aiuer_pkg::t_out_item          o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aiuer_pkg::CFG_AW-1:0]  paddr,
    input  logic [aiuer_pkg::CFG_DW-1:0]  pwdata,
    output logic [aiuer_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready
);
    import aiuer_pkg::*;

    typedef struct packed {
        t_out_item  item;
        logic       use_ram;
    } t_s1;

    // configuration
    logic [47:0] r_device_mac;
    logic [31:0] r_device_ip;
    logic [15:0] r_echo_port;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // receive state
    logic [CNT_W-1:0] r_rx_count,   n_rx_count;
    logic             r_rx_overflow, n_rx_overflow;
    logic             r_rx_busy,     n_rx_busy;
    logic [19:0]      r_ip_sum,      n_ip_sum;
    logic [27:0]      r_icmp_sum,    n_icmp_sum;
    t_hdr             r_hdr,         n_hdr;

    // reply state
    logic             r_reply_pending, n_reply_pending;
    logic [1:0]       r_reply_kind,    n_reply_kind;
    logic [CNT_W-1:0] r_reply_total,   n_reply_total;
    logic [CNT_W-1:0] r_reply_index,   n_reply_index;
    logic [15:0]      r_ip_cks,        n_ip_cks;
    logic [15:0]      r_icmp_cks,      n_icmp_cks;

    // pipeline
    logic      r_s1_valid, n_s1_valid;
    t_s1       r_s1,       n_s1;
    logic      r_out_valid;
    t_out_item r_out,      n_out;
    logic      accept;
    logic      out_adv;

    // datapath helpers
    logic [CNT_W-1:0]  p;
    logic              blocked;
    logic              store;
    logic [15:0]       w;
    logic [16:0]       icmp_limit;
    t_class            cls;
    logic [15:0]       ip_cks_new;
    logic [15:0]       icmp_cks_new;
    logic [CNT_W-1:0]  fi;
    logic [CNT_W-1:0]  f_addr;
    logic              f_use_ram;
    logic [7:0]        f_const;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_AW-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_DEVICE_MAC: prdata = CFG_DW'(r_device_mac);
            REG_DEVICE_IP:  prdata = CFG_DW'(r_device_ip);
            REG_ECHO_PORT:  prdata = CFG_DW'(r_echo_port);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_mac <= '0;
            r_device_ip  <= DEVICE_IP_RST;
            r_echo_port  <= ECHO_PORT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEVICE_MAC: r_device_mac <= pwdata[47:0];
                REG_DEVICE_IP:  r_device_ip  <= pwdata[31:0];
                REG_ECHO_PORT:  r_echo_port  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // The output register frees when empty or taken; the middle stage takes a
    // new word when empty or when it hands its word on.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_adv;
    assign accept     = i_in_valid && !o_in_stall;

    // ---------------- receive path ----------------
    assign p          = r_rx_count;
    assign blocked    = r_reply_pending || r_rx_busy;
    assign store      = !blocked && (p < CNT_W'(FRAME_BYTES));
    assign w          = p[0] ? {8'h00, i_item.data_byte} : {i_item.data_byte, 8'h00};
    assign icmp_limit = {1'b0, r_hdr[16], r_hdr[17]} + 17'(ETH_HDR_LEN);

    always_comb begin
        n_hdr         = r_hdr;
        n_rx_count    = r_rx_count;
        n_rx_busy     = r_rx_busy | blocked;
        n_rx_overflow = r_rx_overflow | (!blocked && !store);
        n_ip_sum      = r_ip_sum;
        n_icmp_sum    = r_icmp_sum;
        if (store) begin
            n_rx_count = p + 1'b1;
            for (int k = 0; k < HDR_BYTES; k++) begin
                if (p == CNT_W'(k)) begin
                    n_hdr[k] = i_item.data_byte;
                end
            end
            // IP header sum skips the checksum field itself
            if (p >= CNT_W'(ETH_HDR_LEN) && p < CNT_W'(IP_END)
                && p != CNT_W'(24) && p != CNT_W'(25)) begin
                n_ip_sum = r_ip_sum + {4'b0, w};
            end
            // ICMP body after the checksum field, up to the IP total length
            if (p >= CNT_W'(ICMP_SUM_START) && 17'(p) < icmp_limit) begin
                n_icmp_sum = r_icmp_sum + {12'b0, w};
            end
        end
    end

    aiuer_classify u_classify (
        .i_hdr       (n_hdr),
        .i_count     (n_rx_count),
        .i_busy      (n_rx_busy),
        .i_overflow  (n_rx_overflow),
        .i_device_ip (r_device_ip),
        .i_echo_port (r_echo_port),
        .o_class     (cls)
    );

    assign ip_cks_new   = fold_not({8'b0, n_ip_sum});
    assign icmp_cks_new = fold_not(n_icmp_sum);

    // ---------------- fetch byte selection ----------------
    // Map the reply index to a frame-buffer address or a constant byte.
    assign fi = r_reply_index;

    always_comb begin
        f_use_ram = 1'b1;
        f_addr    = fi;
        f_const   = 8'h00;
        if (r_reply_kind == K_ARP) begin
            if (fi < CNT_W'(6)) begin
                f_addr = fi + CNT_W'(22);
            end else if (fi < CNT_W'(12)) begin
                f_use_ram = 1'b0;
                f_const   = mac_byte(r_device_mac, 3'(fi - CNT_W'(6)));
            end else if (fi < CNT_W'(22)) begin
                f_use_ram = 1'b0;
                f_const   = ARP_FIXED[4'(fi - CNT_W'(12))];
            end else if (fi < CNT_W'(28)) begin
                f_use_ram = 1'b0;
                f_const   = mac_byte(r_device_mac, 3'(fi - CNT_W'(22)));
            end else if (fi < CNT_W'(32)) begin
                f_use_ram = 1'b0;
                f_const   = ip_byte(r_device_ip, 2'(fi - CNT_W'(28)));
            end else begin
                f_addr = fi - CNT_W'(10);
            end
        end else begin
            if (fi < CNT_W'(6)) begin
                f_addr = fi + CNT_W'(6);
            end else if (fi < CNT_W'(12)) begin
                f_addr = fi - CNT_W'(6);
            end else if (fi == CNT_W'(12)) begin
                f_use_ram = 1'b0;
                f_const   = ETH_IPV4[15:8];
            end else if (fi == CNT_W'(13)) begin
                f_use_ram = 1'b0;
                f_const   = ETH_IPV4[7:0];
            end else if (fi == CNT_W'(24)) begin
                f_use_ram = 1'b0;
                f_const   = r_ip_cks[15:8];
            end else if (fi == CNT_W'(25)) begin
                f_use_ram = 1'b0;
                f_const   = r_ip_cks[7:0];
            end else if (fi >= CNT_W'(26) && fi < CNT_W'(30)) begin
                f_addr = fi + CNT_W'(4);
            end else if (fi >= CNT_W'(30) && fi < CNT_W'(34)) begin
                f_addr = fi - CNT_W'(4);
            end else if (fi < CNT_W'(34)) begin
                f_addr = fi;
            end else if (r_reply_kind == K_ICMP) begin
                // zero type/code, fresh checksum
                if (fi == CNT_W'(34) || fi == CNT_W'(35)) begin
                    f_use_ram = 1'b0;
                end else if (fi == CNT_W'(36)) begin
                    f_use_ram = 1'b0;
                    f_const   = r_icmp_cks[15:8];
                end else if (fi == CNT_W'(37)) begin
                    f_use_ram = 1'b0;
                    f_const   = r_icmp_cks[7:0];
                end
            end else begin
                // swap UDP ports, zero UDP checksum
                if (fi == CNT_W'(34) || fi == CNT_W'(35)) begin
                    f_addr = fi + CNT_W'(2);
                end else if (fi == CNT_W'(36) || fi == CNT_W'(37)) begin
                    f_addr = fi - CNT_W'(2);
                end else if (fi == CNT_W'(40) || fi == CNT_W'(41)) begin
                    f_use_ram = 1'b0;
                end
            end
        end
    end

    // ---------------- state update and middle stage ----------------
    always_comb begin
        n_reply_pending = r_reply_pending;
        n_reply_kind    = r_reply_kind;
        n_reply_total   = r_reply_total;
        n_reply_index   = r_reply_index;
        n_ip_cks        = r_ip_cks;
        n_icmp_cks      = r_icmp_cks;
        n_s1            = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_addr        = p[ADDR_W-1:0];
        if (i_item.op) begin
            if (r_reply_pending) begin
                ram_re                   = accept;
                ram_addr                 = f_addr[ADDR_W-1:0];
                n_s1.use_ram             = f_use_ram;
                n_s1.item.reply_byte     = f_const;
                n_s1.item.reply_valid    = 1'b1;
                if (fi + 1'b1 >= r_reply_total) begin
                    n_s1.item.reply_end = 1'b1;
                    n_reply_pending     = 1'b0;
                    n_reply_index       = '0;
                end else begin
                    n_reply_index = fi + 1'b1;
                end
            end
        end else begin
            ram_we = accept && store;
            if (i_item.last) begin
                n_s1.item.verdict = cls.verdict;
                if (cls.kind != K_NONE) begin
                    n_s1.item.reply_length = 12'(cls.total);
                    n_reply_pending        = 1'b1;
                    n_reply_index          = '0;
                    n_reply_kind           = cls.kind;
                    n_reply_total          = cls.total;
                    if (cls.kind != K_ARP) begin
                        n_ip_cks = ip_cks_new;
                    end
                    if (cls.kind == K_ICMP) begin
                        n_icmp_cks = icmp_cks_new;
                    end
                end
            end
        end
    end

    aiuer_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_item.data_byte),
        .o_rdata (ram_rdata)
    );

    assign n_s1_valid = accept ? 1'b1 : (out_adv ? 1'b0 : r_s1_valid);

    always_comb begin
        n_out = r_s1.item;
        if (r_s1.use_ram) begin
            n_out.reply_byte = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count      <= '0;
            r_rx_overflow   <= 1'b0;
            r_rx_busy       <= 1'b0;
            r_ip_sum        <= '0;
            r_icmp_sum      <= '0;
            r_reply_pending <= 1'b0;
            r_reply_kind    <= K_NONE;
            r_reply_total   <= '0;
            r_reply_index   <= '0;
            r_ip_cks        <= '0;
            r_icmp_cks      <= '0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_reply_pending <= n_reply_pending;
                r_reply_kind    <= n_reply_kind;
                r_reply_total   <= n_reply_total;
                r_reply_index   <= n_reply_index;
                r_ip_cks        <= n_ip_cks;
                r_icmp_cks      <= n_icmp_cks;
                if (!i_item.op) begin
                    if (i_item.last) begin
                        // drop per-frame state once the frame is judged
                        r_rx_count    <= '0;
                        r_rx_overflow <= 1'b0;
                        r_rx_busy     <= 1'b0;
                        r_ip_sum      <= '0;
                        r_icmp_sum    <= '0;
                    end else begin
                        r_rx_count    <= n_rx_count;
                        r_rx_overflow <= n_rx_overflow;
                        r_rx_busy     <= n_rx_busy;
                        r_ip_sum      <= n_ip_sum;
                        r_icmp_sum    <= n_icmp_sum;
                    end
                end
            end
            r_s1_valid <= n_s1_valid;
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && !i_item.op) begin
            r_hdr <= n_hdr;
        end
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (out_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

FILE: rtl/core/aiuer_ram.sv
module aiuer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/aiuer_classify.sv
module aiuer_classify (
    input  aiuer_pkg::t_hdr               i_hdr,
    input  logic [aiuer_pkg::CNT_W-1:0]   i_count,
    input  logic                          i_busy,
    input  logic                          i_overflow,
    input  logic [31:0]                   i_device_ip,
    input  logic [15:0]                   i_echo_port,
    output aiuer_pkg::t_class             o_class
);
    import aiuer_pkg::*;

    logic [16:0] n_x;
    logic [15:0] etype;
    logic [15:0] ip_tot;
    logic [15:0] udp_len;
    logic [16:0] icmp_end;
    logic [16:0] udp_end;

    assign n_x      = 17'(i_count);
    assign etype    = {i_hdr[12], i_hdr[13]};
    assign ip_tot   = {i_hdr[16], i_hdr[17]};
    assign udp_len  = {i_hdr[38], i_hdr[39]};
    assign icmp_end = {1'b0, ip_tot} + 17'(ETH_HDR_LEN);
    assign udp_end  = {1'b0, udp_len} + 17'(IP_END);

    always_comb begin
        o_class = '{verdict: V_UNSUP, kind: K_NONE, total: '0};
        if (i_busy) begin
            o_class.verdict = V_BUSY;
        end else if (i_overflow) begin
            o_class.verdict = V_LONG;
        end else if (n_x < 17'(ETH_HDR_LEN)) begin
            o_class.verdict = V_SHORT;
        end else if (etype == ETH_ARP) begin
            if (n_x < 17'(L4_MIN_LEN)) begin
                o_class.verdict = V_SHORT;
            end else if ({i_hdr[14], i_hdr[15]} != ARP_HTYPE
                         || {i_hdr[16], i_hdr[17]} != ETH_IPV4
                         || i_hdr[18] != ARP_HLEN || i_hdr[19] != ARP_PLEN) begin
                o_class.verdict = V_MALFORM;
            end else if ({i_hdr[20], i_hdr[21]} != ARP_OP_REQ) begin
                o_class.verdict = V_UNSUP;
            end else if ({i_hdr[38], i_hdr[39], i_hdr[40], i_hdr[41]} != i_device_ip) begin
                o_class.verdict = V_NOTOURS;
            end else begin
                o_class = '{verdict: V_ARP, kind: K_ARP, total: CNT_W'(L4_MIN_LEN)};
            end
        end else if (etype != ETH_IPV4) begin
            o_class.verdict = V_UNSUP;
        end else if (n_x < 17'(IP_END)) begin
            o_class.verdict = V_SHORT;
        end else if (i_hdr[14][7:4] != IPV4_VER) begin
            o_class.verdict = V_MALFORM;
        end else if (i_hdr[14][3:0] != IP_IHL) begin
            o_class.verdict = V_UNSUP;
        end else if ({i_hdr[30], i_hdr[31], i_hdr[32], i_hdr[33]} != i_device_ip) begin
            o_class.verdict = V_NOTOURS;
        end else if (i_hdr[23] == PROTO_ICMP) begin
            if (n_x < 17'(L4_MIN_LEN)) begin
                o_class.verdict = V_SHORT;
            end else if (i_hdr[34] != ICMP_ECHO_RQ || i_hdr[35] != 8'h00) begin
                o_class.verdict = V_UNSUP;
            end else if (ip_tot < 16'(ICMP_MIN) || icmp_end > n_x) begin
                o_class.verdict = V_MALFORM;
            end else begin
                o_class = '{verdict: V_ICMP, kind: K_ICMP, total: CNT_W'(icmp_end)};
            end
        end else if (i_hdr[23] == PROTO_UDP) begin
            if (n_x < 17'(L4_MIN_LEN)) begin
                o_class.verdict = V_SHORT;
            end else if ({i_hdr[36], i_hdr[37]} != i_echo_port) begin
                o_class.verdict = V_NOTOURS;
            end else if (udp_len < 16'(UDP_MIN) || udp_end > n_x) begin
                o_class.verdict = V_MALFORM;
            end else begin
                o_class = '{verdict: V_UDP, kind: K_UDP, total: CNT_W'(udp_end)};
            end
        end
    end

endmodule
